// ----- rtl/assert_macros.svh -----
// assertion helpers for the tile pixel mapper
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LTPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ltpm assertion failed");

// next-cycle implication
`define LTPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ltpm assertion failed");

`endif

// ----- rtl/ltpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ltpm_pkg;

  localparam int MAX_TILES_DEF  = 16;
  localparam int MAX_PIXELS_DEF = 16777216;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_NOTILE  = 2'd2;

  localparam logic [2:0] REG_CANVAS_W  = 3'd0;
  localparam logic [2:0] REG_CANVAS_H  = 3'd1;
  localparam logic [2:0] REG_TILE_CNT  = 3'd2;
  localparam logic [2:0] REG_CH_ORDER  = 3'd3;
  localparam logic [2:0] REG_GLOBAL_BR = 3'd4;

  localparam logic [3:0] CO_RGB  = 4'd0;
  localparam logic [3:0] CO_RBG  = 4'd1;
  localparam logic [3:0] CO_GRB  = 4'd2;
  localparam logic [3:0] CO_GBR  = 4'd3;
  localparam logic [3:0] CO_BRG  = 4'd4;
  localparam logic [3:0] CO_BGR  = 4'd5;
  localparam logic [3:0] CO_RGBW = 4'd6;
  localparam logic [3:0] CO_GRBW = 4'd7;
  localparam logic [3:0] CO_BRGW = 4'd8;
  localparam logic [3:0] CO_WRGB = 4'd9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANGE,
    S_SCAN,
    S_XFORM,
    S_LOCAL,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic range_err;
    logic scan_init;
    logic scan_step;
    logic scan_miss;
    logic xform;
    logic local_mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic hit;
    logic scan_end;
  } sts_t;

  typedef struct packed {
    logic [11:0] canvas_width;
    logic [11:0] canvas_height;
    logic [4:0]  tile_count;
    logic [3:0]  byte_order;
    logic [7:0]  global_brightness;
  } cfg_t;

  // floor(a/255), exact for a below 65280
  function automatic logic [7:0] div255(input logic [15:0] a);
    logic [16:0] s;
    s = {1'b0, a} + 17'd1 + 17'(a[15:8]);
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ltpm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ltpm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  tile_slot;
  logic [55:0] tile_word;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  white;
  logic [7:0]  frame_brightness;

  modport source (output valid, op, tile_slot, tile_word, pixel_x, pixel_y, red, green,
                  blue, white, frame_brightness, input ready);
  modport sink (input valid, op, tile_slot, tile_word, pixel_x, pixel_y, red, green,
                blue, white, frame_brightness, output ready);
endinterface

interface ltpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  tile_number;
  logic [23:0] local_index;
  logic [23:0] chain_index;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;

  modport source (output valid, status, tile_number, local_index, chain_index, byte0,
                  byte1, byte2, byte3, input ready);
  modport sink (input valid, status, tile_number, local_index, chain_index, byte0,
                byte1, byte2, byte3, output ready);
endinterface
`default_nettype wire

// ----- rtl/ltpm_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltpm_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [4:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ltpm_pkg::cfg_t      cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width      <= 12'd1;
      cfg.canvas_height     <= 12'd1;
      cfg.tile_count        <= 5'd1;
      cfg.byte_order        <= ltpm_pkg::CO_RGB;
      cfg.global_brightness <= 8'd255;
    end else if (wr) begin
      case (idx)
        ltpm_pkg::REG_CANVAS_W:  cfg.canvas_width      <= pwdata[11:0];
        ltpm_pkg::REG_CANVAS_H:  cfg.canvas_height     <= pwdata[11:0];
        ltpm_pkg::REG_TILE_CNT:  cfg.tile_count        <= pwdata[4:0];
        ltpm_pkg::REG_CH_ORDER:  cfg.byte_order        <= pwdata[3:0];
        ltpm_pkg::REG_GLOBAL_BR: cfg.global_brightness <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ltpm_pkg::REG_CANVAS_W:  prdata = 32'(cfg.canvas_width);
      ltpm_pkg::REG_CANVAS_H:  prdata = 32'(cfg.canvas_height);
      ltpm_pkg::REG_TILE_CNT:  prdata = 32'(cfg.tile_count);
      ltpm_pkg::REG_CH_ORDER:  prdata = 32'(cfg.byte_order);
      ltpm_pkg::REG_GLOBAL_BR: prdata = 32'(cfg.global_brightness);
      default:                 prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/ltpm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ltpm_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  ltpm_pkg::sts_t    sts,
  output ltpm_pkg::cmd_t    cmd
);

  ltpm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltpm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ltpm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == ltpm_pkg::OP_MAP) begin
            cmd.capture = 1'b1;
            state_next  = ltpm_pkg::S_RANGE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ltpm_pkg::S_RANGE: begin
        if (sts.outside) begin
          cmd.range_err = 1'b1;
          state_next    = ltpm_pkg::S_OUT;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = ltpm_pkg::S_SCAN;
        end
      end
      ltpm_pkg::S_SCAN: begin
        if (sts.scan_end) begin
          cmd.scan_miss = 1'b1;
          state_next    = ltpm_pkg::S_OUT;
        end else if (sts.hit) begin
          state_next = ltpm_pkg::S_XFORM;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ltpm_pkg::S_XFORM: begin
        cmd.xform  = 1'b1;
        state_next = ltpm_pkg::S_LOCAL;
      end
      ltpm_pkg::S_LOCAL: begin
        cmd.local_mul = 1'b1;
        state_next    = ltpm_pkg::S_FINISH;
      end
      ltpm_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ltpm_pkg::S_OUT;
      end
      ltpm_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ltpm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ltpm_pkg::S_IDLE;
      end
    endcase
  end

  `LTPM_ASSERT_NXT(a_map_enters_range, state == ltpm_pkg::S_IDLE && in_valid && in_op == ltpm_pkg::OP_MAP, state == ltpm_pkg::S_RANGE)
  `LTPM_ASSERT_NXT(a_hit_goes_xform, state == ltpm_pkg::S_SCAN && !sts.scan_end && sts.hit, state == ltpm_pkg::S_XFORM)
  `LTPM_ASSERT_NXT(a_taken_to_idle, out_valid && out_ready, state == ltpm_pkg::S_IDLE)

endmodule
`default_nettype wire

// ----- rtl/ltpm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ltpm_dp #(
  parameter int MAX_TILES  = ltpm_pkg::MAX_TILES_DEF,
  parameter int MAX_PIXELS = ltpm_pkg::MAX_PIXELS_DEF
) (
  input  wire logic         clk,
  input  ltpm_pkg::cmd_t    cmd,
  output ltpm_pkg::sts_t    sts,
  input  ltpm_pkg::cfg_t    cfg,
  input  wire logic [3:0]   tile_slot,
  input  wire logic [55:0]  tile_word,
  input  wire logic [11:0]  pixel_x,
  input  wire logic [11:0]  pixel_y,
  input  wire logic [7:0]   red,
  input  wire logic [7:0]   green,
  input  wire logic [7:0]   blue,
  input  wire logic [7:0]   white,
  input  wire logic [7:0]   frame_brightness,
  output logic [1:0]        status,
  output logic [3:0]        tile_number,
  output logic [23:0]       local_index,
  output logic [23:0]       chain_index,
  output logic [7:0]        byte0,
  output logic [7:0]        byte1,
  output logic [7:0]        byte2,
  output logic [7:0]        byte3
);

  localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W = $clog2(MAX_TILES + 1);
  localparam int SUM_W = 25 + $clog2(MAX_TILES + 1);

  logic [55:0] tiles [MAX_TILES];
  logic [55:0] tile;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_inc;
  logic [IDX_W-1:0] rd_addr;
  logic [SUM_W-1:0] offset;

  logic [11:0] px, py;
  logic [7:0]  r, g, b, w, fb;
  logic [11:0] major, minor, msize;
  logic [23:0] loc;
  logic [7:0]  level;

  logic [11:0] tx, ty, tw, th;
  logic [1:0]  org, mir, rot;
  logic        trav, serp;
  logic [11:0] x0, y0, x1, y1, x2, y2, xr, yr, pw, ph;
  logic [11:0] maj_c, min_c, msz_c, min_s;
  logic [SUM_W-1:0] sum;
  logic [23:0] abs_c;
  logic [7:0]  sr, sg, sb, sw;

  assign tx   = tile[11:0];
  assign ty   = tile[23:12];
  assign tw   = tile[35:24];
  assign th   = tile[47:36];
  assign org  = tile[49:48];
  assign mir  = tile[51:50];
  assign rot  = tile[53:52];
  assign trav = tile[54];
  assign serp = tile[55];

  assign ptr_inc = ptr + CNT_W'(1);
  assign rd_addr = cmd.scan_init ? '0 : IDX_W'(ptr_inc);

  assign sts.outside  = (px >= cfg.canvas_width) || (py >= cfg.canvas_height);
  assign sts.scan_end = (32'(ptr) >= 32'(cfg.tile_count)) || (32'(ptr) >= MAX_TILES);
  assign sts.hit      = (px >= tx) && (py >= ty) && ({1'b0, px} < ({1'b0, tx} + {1'b0, tw}))
                        && ({1'b0, py} < ({1'b0, ty} + {1'b0, th}));

  always_ff @(posedge clk) begin
    if (cmd.load && (32'(tile_slot) < MAX_TILES)) begin
      tiles[IDX_W'(tile_slot)] <= tile_word;
    end
    if (cmd.scan_init || cmd.scan_step) begin
      tile <= tiles[rd_addr];
    end
  end

  always_comb begin
    x0 = px - tx;
    y0 = py - ty;
    x1 = org[0] ? (tw - 12'd1 - x0) : x0;
    y1 = org[1] ? (th - 12'd1 - y0) : y0;
    x2 = mir[0] ? (tw - 12'd1 - x1) : x1;
    y2 = mir[1] ? (th - 12'd1 - y1) : y1;
    case (rot)
      2'd1: begin
        xr = th - 12'd1 - y2;
        yr = x2;
      end
      2'd2: begin
        xr = tw - 12'd1 - x2;
        yr = th - 12'd1 - y2;
      end
      2'd3: begin
        xr = y2;
        yr = tw - 12'd1 - x2;
      end
      default: begin
        xr = x2;
        yr = y2;
      end
    endcase
    pw    = rot[0] ? th : tw;
    ph    = rot[0] ? tw : th;
    maj_c = trav ? xr : yr;
    min_c = trav ? yr : xr;
    msz_c = trav ? ph : pw;
    min_s = (serp && maj_c[0]) ? (msz_c - 12'd1 - min_c) : min_c;
  end

  assign sum   = offset + SUM_W'(loc);
  assign abs_c = (sum >= SUM_W'(MAX_PIXELS)) ? 24'(MAX_PIXELS - 1) : sum[23:0];
  assign sr    = ltpm_pkg::div255(16'(r) * 16'(level) + 16'd127);
  assign sg    = ltpm_pkg::div255(16'(g) * 16'(level) + 16'd127);
  assign sb    = ltpm_pkg::div255(16'(b) * 16'(level) + 16'd127);
  assign sw    = ltpm_pkg::div255(16'(w) * 16'(level) + 16'd127);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= pixel_x;
      py <= pixel_y;
      r  <= red;
      g  <= green;
      b  <= blue;
      w  <= white;
      fb <= frame_brightness;
    end
    if (cmd.scan_init) begin
      ptr    <= '0;
      offset <= '0;
    end else if (cmd.scan_step) begin
      ptr    <= ptr_inc;
      offset <= offset + SUM_W'(24'(tw) * 24'(th));
    end
    if (cmd.xform) begin
      major <= maj_c;
      minor <= min_s;
      msize <= msz_c;
    end
    if (cmd.local_mul) begin
      loc   <= 24'(major) * 24'(msize) + 24'(minor);
      level <= ltpm_pkg::div255(16'(fb) * 16'(cfg.global_brightness));
    end
    if (cmd.range_err || cmd.scan_miss) begin
      status         <= cmd.range_err ? ltpm_pkg::ST_OUTSIDE : ltpm_pkg::ST_NOTILE;
      tile_number    <= '0;
      local_index    <= '0;
      chain_index    <= '0;
      byte0          <= '0;
      byte1          <= '0;
      byte2          <= '0;
      byte3          <= '0;
    end else if (cmd.finish) begin
      status         <= ltpm_pkg::ST_OK;
      tile_number    <= 4'(ptr);
      local_index    <= loc;
      chain_index    <= abs_c;
      case (cfg.byte_order)
        ltpm_pkg::CO_RBG: begin
          byte0 <= sr; byte1 <= sb; byte2 <= sg; byte3 <= '0;
        end
        ltpm_pkg::CO_GRB: begin
          byte0 <= sg; byte1 <= sr; byte2 <= sb; byte3 <= '0;
        end
        ltpm_pkg::CO_GBR: begin
          byte0 <= sg; byte1 <= sb; byte2 <= sr; byte3 <= '0;
        end
        ltpm_pkg::CO_BRG: begin
          byte0 <= sb; byte1 <= sr; byte2 <= sg; byte3 <= '0;
        end
        ltpm_pkg::CO_BGR: begin
          byte0 <= sb; byte1 <= sg; byte2 <= sr; byte3 <= '0;
        end
        ltpm_pkg::CO_RGBW: begin
          byte0 <= sr; byte1 <= sg; byte2 <= sb; byte3 <= sw;
        end
        ltpm_pkg::CO_GRBW: begin
          byte0 <= sg; byte1 <= sr; byte2 <= sb; byte3 <= sw;
        end
        ltpm_pkg::CO_BRGW: begin
          byte0 <= sb; byte1 <= sr; byte2 <= sg; byte3 <= sw;
        end
        ltpm_pkg::CO_WRGB: begin
          byte0 <= sw; byte1 <= sr; byte2 <= sg; byte3 <= sb;
        end
        default: begin
          byte0 <= sr; byte1 <= sg; byte2 <= sb; byte3 <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/led_tile_pixel_mapper.sv -----
// channel  direction  contents
// req      in         op, tile_slot, tile_word, pixel_x/y, colour, frame_brightness
// rsp      out        status, tile_number, local/chain index, byte0..byte3
// apb      in         canvas size, tile count, channel order, global brightness
//
// a load item is written while idle; a pixel outside the canvas goes to rsp after
// the range check; a match scans to its tile, then transform, local index, finish;
// a miss scans n, the tile count capped at MAX_TILES, reading one entry per cycle
// one item at a time: req is ready only while idle
// rsp holds its item until taken; rst is synchronous, active high
`timescale 1ns / 1ps
`default_nettype none
module led_tile_pixel_mapper #(
  parameter int MAX_TILES  = ltpm_pkg::MAX_TILES_DEF,
  parameter int MAX_PIXELS = ltpm_pkg::MAX_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  ltpm_in_if.sink          req,
  ltpm_out_if.source       rsp
);

  ltpm_pkg::cfg_t cfg;
  ltpm_pkg::cmd_t cmd;
  ltpm_pkg::sts_t sts;

  ltpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ltpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_op     (req.op),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ltpm_dp #(
    .MAX_TILES  (MAX_TILES),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .cfg              (cfg),
    .tile_slot        (req.tile_slot),
    .tile_word        (req.tile_word),
    .pixel_x          (req.pixel_x),
    .pixel_y          (req.pixel_y),
    .red              (req.red),
    .green            (req.green),
    .blue             (req.blue),
    .white            (req.white),
    .frame_brightness (req.frame_brightness),
    .status           (rsp.status),
    .tile_number      (rsp.tile_number),
    .local_index      (rsp.local_index),
    .chain_index      (rsp.chain_index),
    .byte0            (rsp.byte0),
    .byte1            (rsp.byte1),
    .byte2            (rsp.byte2),
    .byte3            (rsp.byte3)
  );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ltpm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 140;

  typedef enum logic {RK_ITEM, RK_CFG} row_kind_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  slot;
    logic [55:0] word;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  w;
    logic [7:0]  fb;
  } pixel_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  tile;
    logic [23:0] loc;
    logic [23:0] abs_idx;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
  } mapped_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    pixel_item_t it;
    bit          typed;
    mapped_t     want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ltpm_in_if req ();
  ltpm_out_if rsp ();

  led_tile_pixel_mapper dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  logic [55:0] tiles [16];
  logic [11:0] cw_sh;
  logic [11:0] ch_sh;
  logic [4:0]  cnt_sh;
  logic [3:0]  order_sh;
  logic [7:0]  gbr_sh;

  mapped_t pending_maps[$];
  bit failed = 1'b0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int taken = 0;
  int cycles = 0;
  plan_row_t plan[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [55:0] pack_tile(input int x, input int y, input int w, input int h,
                                            input int org, input int mir, input int rot,
                                            input int trav, input int serp);
    return {1'(serp), 1'(trav), 2'(rot), 2'(mir), 2'(org), 12'(h), 12'(w), 12'(y), 12'(x)};
  endfunction

  function automatic logic [7:0] scale_level(input int unsigned v, input int unsigned level);
    return 8'((v * level + 127) / 255);
  endfunction

  function automatic bit map_pixel(input pixel_item_t it, output mapped_t m);
    int unsigned px, py, n, tx, ty, tw, th, org, mir, rot, trav, serp;
    int unsigned x, y, old, pw, ph, major, minor, msize, level;
    longint unsigned offset, loc;
    logic [7:0] r, g, b, w;
    int hit;
    m = '0;
    if (it.op == OP_LOAD) begin
      tiles[it.slot] = it.word;
      return 1'b0;
    end
    px = it.x;
    py = it.y;
    if (px >= cw_sh || py >= ch_sh) begin
      m.status = ST_OUTSIDE;
      return 1'b1;
    end
    n = (cnt_sh > 16) ? 16 : cnt_sh;
    offset = 0;
    loc = 0;
    hit = -1;
    for (int i = 0; i < n; i++) begin
      tx = tiles[i][11:0];
      ty = tiles[i][23:12];
      tw = tiles[i][35:24];
      th = tiles[i][47:36];
      org = tiles[i][49:48];
      mir = tiles[i][51:50];
      rot = tiles[i][53:52];
      trav = tiles[i][54];
      serp = tiles[i][55];
      if (px < tx || py < ty || px >= tx + tw || py >= ty + th) begin
        offset += longint'(tw) * th;
        continue;
      end
      x = px - tx;
      y = py - ty;
      if (org == 1 || org == 3) x = tw - 1 - x;
      if (org == 2 || org == 3) y = th - 1 - y;
      if (mir == 1 || mir == 3) x = tw - 1 - x;
      if (mir == 2 || mir == 3) y = th - 1 - y;
      if (rot == 1) begin
        old = x; x = th - 1 - y; y = old;
      end else if (rot == 2) begin
        x = tw - 1 - x; y = th - 1 - y;
      end else if (rot == 3) begin
        old = x; x = y; y = tw - 1 - old;
      end
      pw = (rot == 1 || rot == 3) ? th : tw;
      ph = (rot == 1 || rot == 3) ? tw : th;
      major = trav == 0 ? y : x;
      minor = trav == 0 ? x : y;
      msize = trav == 0 ? pw : ph;
      if (serp == 1 && major[0]) minor = msize - 1 - minor;
      loc = longint'(major) * msize + minor;
      hit = i;
      break;
    end
    if (hit < 0) begin
      m.status = ST_NOTILE;
      return 1'b1;
    end
    offset += loc;
    if (offset >= MAX_PIXELS_DEF) offset = MAX_PIXELS_DEF - 1;
    level = int'(it.fb) * int'(gbr_sh) / 255;
    r = scale_level(it.r, level);
    g = scale_level(it.g, level);
    b = scale_level(it.b, level);
    w = scale_level(it.w, level);
    m.status = ST_OK;
    m.tile = 4'(hit);
    m.loc = loc[23:0];
    m.abs_idx = offset[23:0];
    case (order_sh)
      CO_RBG:  {m.b0, m.b1, m.b2} = {r, b, g};
      CO_GRB:  {m.b0, m.b1, m.b2} = {g, r, b};
      CO_GBR:  {m.b0, m.b1, m.b2} = {g, b, r};
      CO_BRG:  {m.b0, m.b1, m.b2} = {b, r, g};
      CO_BGR:  {m.b0, m.b1, m.b2} = {b, g, r};
      CO_RGBW: {m.b0, m.b1, m.b2, m.b3} = {r, g, b, w};
      CO_GRBW: {m.b0, m.b1, m.b2, m.b3} = {g, r, b, w};
      CO_BRGW: {m.b0, m.b1, m.b2, m.b3} = {b, r, g, w};
      CO_WRGB: {m.b0, m.b1, m.b2, m.b3} = {w, r, g, b};
      default: {m.b0, m.b1, m.b2} = {r, g, b};
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(input pixel_item_t it, input bit typed, input mapped_t want);
    mapped_t m;
    bit ok;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.op <= it.op;
    req.tile_slot <= it.slot;
    req.tile_word <= it.word;
    req.pixel_x <= it.x;
    req.pixel_y <= it.y;
    req.red <= it.r;
    req.green <= it.g;
    req.blue <= it.b;
    req.white <= it.w;
    req.frame_brightness <= it.fb;
    req.valid <= 1'b1;
    do begin
      @(negedge clk);
      ok = req.ready;
      if (ok) begin
        if (typed) pending_maps = {pending_maps, want};
        else if (map_pixel(it, m)) pending_maps = {pending_maps, m};
      end
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    bit ok;
    req.valid <= 1'b0;
    wait (pending_maps.size() == 0);
    @(posedge clk);
    repeat (30) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ok = pready;
      @(posedge clk);
    end while (!ok);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CANVAS_W:  cw_sh = val[11:0];
      REG_CANVAS_H:  ch_sh = val[11:0];
      REG_TILE_CNT:  cnt_sh = val[4:0];
      REG_CH_ORDER:  order_sh = val[3:0];
      REG_GLOBAL_BR: gbr_sh = val[7:0];
      default: ;
    endcase
  endtask

  function automatic pixel_item_t load_of(input int slot, input logic [55:0] word);
    pixel_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.slot = 4'(slot);
    it.word = word;
    return it;
  endfunction

  function automatic pixel_item_t pixel_of(input int x, input int y, input int r, input int g,
                                           input int b, input int w, input int fb);
    pixel_item_t it;
    it = '0;
    it.op = OP_MAP;
    it.x = 12'(x);
    it.y = 12'(y);
    it.r = 8'(r);
    it.g = 8'(g);
    it.b = 8'(b);
    it.w = 8'(w);
    it.fb = 8'(fb);
    return it;
  endfunction

  function automatic void add_item(input pixel_item_t it, input bit typed, input mapped_t want);
    plan = {plan, plan_row_t'{RK_ITEM, REG_CANVAS_W, 32'd0, it, typed, want}};
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input int val);
    plan = {plan, plan_row_t'{RK_CFG, idx, 32'(val), '0, 1'b0, '0}};
  endfunction

  function automatic logic [55:0] any_word();
    return 56'({$urandom, $urandom});
  endfunction

  // receiver: changing stall patterns, one long hold-off
  initial begin
    int mode, left, hold;
    bit held;
    rsp.ready = 1'b0;
    mode = 0;
    left = 0;
    hold = 0;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && taken >= 300) begin
        held = 1'b1;
        hold = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else case (mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= $urandom_range(0, 1);
        2: rsp.ready <= ($urandom_range(0, 3) == 0);
        default: rsp.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(negedge clk) begin
    mapped_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      taken <= taken + 1;
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, rsp.status);
        failed = 1'b1;
      end else begin
        e = pending_maps.pop_front();
        if (rsp.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
          failed = 1'b1;
        end
        if (rsp.tile_number !== e.tile) begin
          $display("%0t: tile_number exp %0d got %0d", $time, e.tile, rsp.tile_number);
          failed = 1'b1;
        end
        if (rsp.local_index !== e.loc) begin
          $display("%0t: local_index exp %0d got %0d", $time, e.loc, rsp.local_index);
          failed = 1'b1;
        end
        if (rsp.chain_index !== e.abs_idx) begin
          $display("%0t: chain_index exp %0d got %0d", $time, e.abs_idx,
                   rsp.chain_index);
          failed = 1'b1;
        end
        if ({rsp.byte0, rsp.byte1, rsp.byte2, rsp.byte3} !== {e.b0, e.b1, e.b2, e.b3}) begin
          $display("%0t: bytes exp %h got %h", $time, {e.b0, e.b1, e.b2, e.b3},
                   {rsp.byte0, rsp.byte1, rsp.byte2, rsp.byte3});
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    mapped_t none, want;
    pixel_item_t it;
    logic [55:0] layout [16];
    int cw, ch, cols, rows, k, tw, th, sel;
    req.valid = 1'b0;
    req.op = OP_LOAD;
    req.tile_slot = '0;
    req.tile_word = '0;
    req.pixel_x = '0;
    req.pixel_y = '0;
    req.red = '0;
    req.green = '0;
    req.blue = '0;
    req.white = '0;
    req.frame_brightness = '0;
    for (int i = 0; i < 16; i++) tiles[i] = '0;
    cw_sh = 12'd1;
    ch_sh = 12'd1;
    cnt_sh = 5'd1;
    order_sh = CO_RGB;
    gbr_sh = 8'd255;
    none = '0;

    // directed
    want = '0;
    want.status = ST_OUTSIDE;
    add_item(pixel_of(3, 0, 1, 2, 3, 4, 255), 1'b1, want);
    add_item(load_of(0, pack_tile(0, 0, 1, 1, 0, 0, 0, 0, 0)), 1'b0, none);
    want = '0;
    {want.b0, want.b1, want.b2} = {8'd200, 8'd100, 8'd50};
    add_item(pixel_of(0, 0, 200, 100, 50, 9, 255), 1'b1, want);
    want = '0;
    add_item(pixel_of(0, 0, 255, 255, 255, 255, 0), 1'b1, want);
    add_cfg(REG_TILE_CNT, 0);
    want = '0;
    want.status = ST_NOTILE;
    add_item(pixel_of(0, 0, 255, 255, 255, 255, 255), 1'b1, want);
    add_cfg(REG_CANVAS_W, 4095);
    add_cfg(REG_CANVAS_H, 4095);
    add_cfg(REG_TILE_CNT, 3);
    add_cfg(REG_GLOBAL_BR, 128);
    add_cfg(REG_CH_ORDER, CO_WRGB);
    add_item(load_of(0, pack_tile(4095, 0, 4095, 4095, 0, 0, 0, 0, 0)), 1'b0, none);
    add_item(load_of(1, pack_tile(4095, 4095, 4095, 4095, 0, 0, 0, 0, 0)), 1'b0, none);
    add_item(load_of(2, pack_tile(0, 0, 4095, 4095, 3, 1, 1, 1, 1)), 1'b0, none);
    add_item(pixel_of(4094, 4094, 255, 0, 255, 255, 255), 1'b0, none);
    add_item(pixel_of(0, 0, 0, 255, 0, 128, 200), 1'b0, none);
    want = '0;
    want.status = ST_OUTSIDE;
    add_item(pixel_of(4095, 0, 1, 1, 1, 1, 1), 1'b1, want);
    add_item(pixel_of(0, 4095, 1, 1, 1, 1, 1), 1'b1, want);
    add_cfg(REG_CH_ORDER, 13);
    add_item(pixel_of(17, 3000, 10, 20, 30, 40, 255), 1'b0, none);
    add_cfg(REG_CH_ORDER, CO_RGBW);
    add_item(pixel_of(2048, 1, 255, 255, 255, 255, 255), 1'b0, none);
    add_cfg(REG_GLOBAL_BR, 0);
    add_item(pixel_of(1, 2048, 255, 255, 255, 255, 255), 1'b0, none);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == RK_CFG) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else send_item(plan[i].it, plan[i].typed, plan[i].want);
    end

    // random phases: a fresh tiling each time, then mostly pixel items
    for (int p = 0; p < PHASES; p++) begin
      no_gaps = (p % 4 == 1);
      sel = $urandom_range(0, 19);
      cw = sel == 0 ? 4095 : sel == 1 ? $urandom_range(0, 4095) : $urandom_range(1, 48);
      sel = $urandom_range(0, 19);
      ch = sel == 0 ? 4095 : sel == 1 ? $urandom_range(0, 4095) : $urandom_range(1, 48);
      if (p == PHASES - 1) begin
        cw = 4095;
        ch = 4095;
      end
      write_reg(REG_CANVAS_W, cw);
      write_reg(REG_CANVAS_H, ch);
      sel = $urandom_range(0, 19);
      write_reg(REG_TILE_CNT, sel < 2 ? 0 : sel < 5 ? $urandom_range(17, 31) :
                sel < 7 ? 16 : $urandom_range(1, 16));
      write_reg(REG_CH_ORDER, p < 10 ? p : $urandom_range(0, 15));
      sel = $urandom_range(0, 19);
      write_reg(REG_GLOBAL_BR, sel < 3 ? 0 : sel < 7 ? 255 : $urandom_range(0, 255));
      cols = $urandom_range(1, 4);
      rows = $urandom_range(1, 4);
      tw = ((cw == 0 ? 1 : cw) + cols - 1) / cols;
      th = ((ch == 0 ? 1 : ch) + rows - 1) / rows;
      k = 0;
      for (int ry = 0; ry < rows; ry++)
        for (int rx = 0; rx < cols; rx++) begin
          layout[k] = pack_tile(rx * tw, ry * th, tw, th, $urandom_range(0, 3),
                                $urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 1), $urandom_range(0, 1));
          if ($urandom_range(0, 9) == 0) layout[k] = any_word();
          k++;
        end
      for (int s = k; s < 16; s++) layout[s] = any_word();
      for (int s = 0; s < 16; s++) send_item(load_of(s, layout[s]), 1'b0, none);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          k = $urandom_range(0, 15);
          send_item(load_of(k, $urandom_range(0, 1) ? any_word() : layout[k]), 1'b0, none);
        end else begin
          if ($urandom_range(0, 6) == 0)
            it = pixel_of($urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0, 0, 0, 0);
          else
            it = pixel_of($urandom_range(0, cw == 0 ? 0 : cw - 1),
                          $urandom_range(0, ch == 0 ? 0 : ch - 1), 0, 0, 0, 0, 0);
          it.r = 8'($urandom_range(0, 255));
          it.g = 8'($urandom_range(0, 255));
          it.b = 8'($urandom_range(0, 255));
          it.w = 8'($urandom_range(0, 255));
          sel = $urandom_range(0, 9);
          it.fb = sel == 0 ? 8'd0 : sel == 1 ? 8'd255 : 8'($urandom_range(0, 255));
          it.slot = 4'($urandom_range(0, 15));
          it.word = any_word();
          send_item(it, 1'b0, none);
        end
      end
    end

    req.valid <= 1'b0;
    wait (pending_maps.size() == 0);
    repeat (40) @(posedge clk);
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
